/* hdl/hid_message_reassembler_unit_assert.svh */
// ----------------------------------------------------------------------------
// hid message reassembler assertion macros
// concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef HID_MESSAGE_REASSEMBLER_UNIT_ASSERT_SVH
`define HID_MESSAGE_REASSEMBLER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled during reset
`define HMR_ASSERT_IMPLIES(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("hmr assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define HMR_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("hmr assertion failed: next-cycle implication");

`else

`define HMR_ASSERT_IMPLIES(name, clk, rst_n, pre, post)
`define HMR_ASSERT_NEXT(name, clk, rst_n, pre, post)

`endif

`endif

/* hdl/hmr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmr_pkg
// shared types and constants of the hid message reassembler
// ----------------------------------------------------------------------------
package hmr_pkg;

    localparam logic [31:0] BCAST_CID    = 32'hFFFF_FFFF;
    localparam logic [7:0]  CMD_PING     = 8'h81;
    localparam logic [7:0]  CMD_MSG      = 8'h83;
    localparam logic [7:0]  CMD_INIT     = 8'h86;
    localparam logic [7:0]  CMD_WINK     = 8'h88;
    localparam logic [7:0]  VENDOR_FIRST = 8'hC0;
    localparam logic [5:0]  INIT_CHUNK   = 6'd57;
    localparam logic [5:0]  CONT_CHUNK   = 6'd59;

    localparam logic        U2F_ENABLE_RESET = 1'b1;
    localparam logic [15:0] TIMEOUT_RESET    = 16'd500;
    localparam logic [7:0]  TICK_RESET       = 8'd40;
    localparam logic [7:0]  WALLET_RESET     = 8'd193;

    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_STORE = 3'd1,
        ACT_DONE  = 3'd2,
        ACT_ERR   = 3'd3,
        ACT_INIT  = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_CMD     = 3'd1,
        ERR_LEN     = 3'd2,
        ERR_SEQ     = 3'd3,
        ERR_TIMEOUT = 3'd4,
        ERR_BUSY    = 3'd5,
        ERR_CID     = 3'd6
    } err_t;

    typedef enum logic [1:0] {
        CFG_U2F_ENABLE = 2'd0,
        CFG_TIMEOUT_MS = 2'd1,
        CFG_TICK_MS    = 2'd2,
        CFG_WALLET_CMD = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic        u2f_enable;
        logic [15:0] timeout_ms;
        logic [7:0]  tick_ms;
        logic [7:0]  wallet_cmd;
    } hmr_cfg_t;

    typedef struct packed {
        logic        req_type;
        logic [31:0] frame_cid;
        logic [7:0]  frame_kind;
        logic [15:0] frame_len;
    } hmr_item_t;

    typedef struct packed {
        action_t     action;
        logic [31:0] reply_cid;
        err_t        error_kind;
        logic [12:0] write_offset;
        logic [5:0]  chunk_bytes;
        logic [7:0]  msg_cmd;
        logic [12:0] msg_length;
        logic        flush_replies;
        logic        need_new_cid;
    } hmr_result_t;

endpackage

/* hdl/hmr_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmr_cfg_regs
// configuration register file, written through the cfg channel
// ----------------------------------------------------------------------------
module hmr_cfg_regs (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  hmr_pkg::cfg_idx_t    cfg_index,
    input  logic [15:0]          cfg_data,
    output hmr_pkg::hmr_cfg_t    cfg
);
    import hmr_pkg::*;

    hmr_cfg_t cfg_reg;

    // registers are always writable
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.u2f_enable <= U2F_ENABLE_RESET;
            cfg_reg.timeout_ms <= TIMEOUT_RESET;
            cfg_reg.tick_ms    <= TICK_RESET;
            cfg_reg.wallet_cmd <= WALLET_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_U2F_ENABLE: cfg_reg.u2f_enable <= cfg_data[0];
                CFG_TIMEOUT_MS: cfg_reg.timeout_ms <= cfg_data;
                CFG_TICK_MS:    cfg_reg.tick_ms    <= cfg_data[7:0];
                CFG_WALLET_CMD: cfg_reg.wallet_cmd <= cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

endmodule

/* hdl/hmr_core.sv */
`timescale 1ns / 1ps
`include "hid_message_reassembler_unit_assert.svh"
// ----------------------------------------------------------------------------
// hmr_core
// open-message state and the per-frame decision logic
// ----------------------------------------------------------------------------
module hmr_core #(
    parameter int BUFFER_BYTES = 4096
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  hmr_pkg::hmr_cfg_t     cfg,
    input  hmr_pkg::hmr_item_t    item,
    input  logic                  step,
    output hmr_pkg::hmr_result_t  result
);
    import hmr_pkg::*;

    localparam logic [15:0] BUF_LEN  = 16'(BUFFER_BYTES);
    localparam logic [13:0] BUF_SUM  = 14'(BUFFER_BYTES);
    localparam logic [12:0] BUF_RECV = 13'(BUFFER_BYTES);

    logic        active_reg,   active_next;
    logic [31:0] channel_reg,  channel_next;
    logic [7:0]  seq_reg,      seq_next;
    logic [12:0] recv_reg,     recv_next;
    logic [12:0] len_reg,      len_next;
    logic [7:0]  cmd_reg,      cmd_next;
    logic [15:0] elapsed_reg,  elapsed_next;

    logic        cid_zero;
    logic        cid_bcast;
    logic        same_cid;
    logic [16:0] elapsed_sum;
    logic [15:0] elapsed_sat;
    logic [13:0] recv_sum;
    logic        do_chunk;
    logic [12:0] chunk_off;
    logic [5:0]  chunk_n;
    logic [7:0]  done_cmd;
    logic [12:0] done_len;
    hmr_result_t res;

    assign cid_zero    = (item.frame_cid == '0);
    assign cid_bcast   = (item.frame_cid == BCAST_CID);
    assign same_cid    = (item.frame_cid == channel_reg);
    assign elapsed_sum = {1'b0, elapsed_reg} + {9'd0, cfg.tick_ms};
    assign elapsed_sat = elapsed_sum[16] ? 16'hFFFF : elapsed_sum[15:0];
    assign recv_sum    = {1'b0, recv_reg} + {8'd0, CONT_CHUNK};

    always_comb begin
        active_next  = active_reg;
        channel_next = channel_reg;
        seq_next     = seq_reg;
        recv_next    = recv_reg;
        len_next     = len_reg;
        cmd_next     = cmd_reg;
        elapsed_next = elapsed_reg;
        res          = '0;
        do_chunk     = 1'b0;
        chunk_off    = '0;
        chunk_n      = '0;
        done_cmd     = '0;
        done_len     = '0;

        if (item.req_type) begin
            // timer tick
            if (active_reg) begin
                elapsed_next = elapsed_sat;
                if (elapsed_sat > cfg.timeout_ms) begin
                    active_next    = 1'b0;
                    seq_next       = '0;
                    recv_next      = '0;
                    len_next       = '0;
                    cmd_next       = '0;
                    res.action     = ACT_ERR;
                    res.reply_cid  = channel_reg;
                    res.error_kind = ERR_TIMEOUT;
                end
            end
        end else if (item.frame_kind[7]) begin
            if (item.frame_kind == CMD_INIT) begin
                if (cid_zero) begin
                    res.action     = ACT_ERR;
                    res.error_kind = ERR_CID;
                end else begin
                    res.action       = ACT_INIT;
                    res.reply_cid    = item.frame_cid;
                    res.need_new_cid = cid_bcast;
                end
                if (same_cid) begin
                    active_next = 1'b0;
                    seq_next    = '0;
                    recv_next   = '0;
                    len_next    = '0;
                    cmd_next    = '0;
                end
            end else if (active_reg) begin
                res.action    = ACT_ERR;
                res.reply_cid = item.frame_cid;
                if (same_cid) begin
                    active_next       = 1'b0;
                    seq_next          = '0;
                    recv_next         = '0;
                    len_next          = '0;
                    cmd_next          = '0;
                    res.error_kind    = ERR_SEQ;
                    res.flush_replies = 1'b1;
                end else begin
                    res.error_kind = ERR_BUSY;
                end
            end else if (cid_bcast || cid_zero) begin
                res.action     = ACT_ERR;
                res.reply_cid  = item.frame_cid;
                res.error_kind = ERR_CID;
            end else if (item.frame_len > BUF_LEN) begin
                res.action     = ACT_ERR;
                res.reply_cid  = item.frame_cid;
                res.error_kind = ERR_LEN;
            end else begin
                // open a new message with the init chunk
                active_next  = 1'b1;
                channel_next = item.frame_cid;
                seq_next     = '0;
                recv_next    = 13'(INIT_CHUNK);
                len_next     = item.frame_len[12:0];
                cmd_next     = item.frame_kind;
                elapsed_next = '0;
                do_chunk     = 1'b1;
                chunk_off    = '0;
                chunk_n      = INIT_CHUNK;
            end
        end else if (active_reg) begin
            // continuation frame
            if (!same_cid) begin
                res.action     = ACT_ERR;
                res.reply_cid  = item.frame_cid;
                res.error_kind = ERR_BUSY;
            end else if (item.frame_kind != seq_reg) begin
                active_next       = 1'b0;
                seq_next          = '0;
                recv_next         = '0;
                len_next          = '0;
                cmd_next          = '0;
                res.action        = ACT_ERR;
                res.reply_cid     = item.frame_cid;
                res.error_kind    = ERR_SEQ;
                res.flush_replies = 1'b1;
            end else if (recv_reg < len_reg && recv_sum <= BUF_SUM) begin
                seq_next  = seq_reg + 8'd1;
                recv_next = recv_sum[12:0];
                do_chunk  = 1'b1;
                chunk_off = recv_reg;
                chunk_n   = CONT_CHUNK;
            end
        end

        if (do_chunk) begin
            res.write_offset = chunk_off;
            res.chunk_bytes  = chunk_n;
            if (recv_next < len_next) begin
                res.action = ACT_STORE;
            end else begin
                // message complete: dispatch decision, then close
                done_cmd       = cmd_next;
                done_len       = len_next;
                res.reply_cid  = channel_next;
                res.msg_cmd    = done_cmd;
                res.msg_length = done_len;
                res.action     = ACT_ERR;
                if (done_cmd < VENDOR_FIRST && !cfg.u2f_enable) begin
                    res.error_kind = ERR_BUSY;
                end else if (done_cmd == CMD_PING || done_cmd == CMD_MSG) begin
                    res.action = ACT_DONE;
                end else if (done_cmd == CMD_WINK) begin
                    if (done_len != '0) begin
                        res.error_kind = ERR_LEN;
                    end else begin
                        res.action = ACT_DONE;
                    end
                end else if (done_cmd == cfg.wallet_cmd) begin
                    res.action = ACT_DONE;
                end else begin
                    res.error_kind = ERR_CMD;
                end
                active_next  = 1'b0;
                seq_next     = '0;
                recv_next    = '0;
                len_next     = '0;
                cmd_next     = '0;
                channel_next = '0;
            end
        end
    end

    assign result = res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            channel_reg <= '0;
            seq_reg     <= '0;
            recv_reg    <= '0;
            len_reg     <= '0;
            cmd_reg     <= '0;
            elapsed_reg <= '0;
        end else if (step) begin
            active_reg  <= active_next;
            channel_reg <= channel_next;
            seq_reg     <= seq_next;
            recv_reg    <= recv_next;
            len_reg     <= len_next;
            cmd_reg     <= cmd_next;
            elapsed_reg <= elapsed_next;
        end
    end

    // an idle reassembler holds no partial message
    `HMR_ASSERT_IMPLIES(a_idle_empty, aclk, aresetn, !active_reg, recv_reg == '0 && len_reg == '0)
    // stored bytes never run past the buffer
    `HMR_ASSERT_IMPLIES(a_recv_bound, aclk, aresetn, active_reg, recv_reg <= BUF_RECV)
    // an open message always sits on a real channel
    `HMR_ASSERT_IMPLIES(a_open_cid, aclk, aresetn, active_reg, channel_reg != '0 && channel_reg != BCAST_CID)

endmodule

/* hdl/hid_message_reassembler_unit.sv */
`timescale 1ns / 1ps
`include "hid_message_reassembler_unit_assert.svh"
// ----------------------------------------------------------------------------
// hid_message_reassembler_unit
// u2f hid frame reassembly: one open channel, one result per frame or tick
// ----------------------------------------------------------------------------
//  channel   direction  ports                        carries
//  s_        in         s_tvalid s_tready s_tdata    frame header or timer tick
//                       s_tuser
//  m_        out        m_tvalid m_tready m_tdata    action, reply channel, error,
//                       m_tuser                      chunk and dispatch info
//  cfg_      in         cfg_valid cfg_ready          register index and value
//                       cfg_index cfg_data
//
//  one transaction per cycle sustained while m_tready is high; an item waits in the
//  input register and its result enters the output register when the item advances
//  aresetn is synchronous, active low: clears channel state and config to defaults
//  an input transaction is taken whenever the input register is empty or moving
//  a stalled result holds in the output register; only m_tready back-pressures
// ----------------------------------------------------------------------------
module hid_message_reassembler_unit #(
    parameter int BUFFER_BYTES = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,    // frame_cid[31:0], frame_kind[39:32], frame_len[55:40]
    input  logic        s_tuser,    // req_type
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,    // reply_cid[31:0], error_kind[34:32],
                                    // write_offset[47:35], chunk_bytes[53:48],
                                    // msg_cmd[61:54], msg_length[74:62],
                                    // flush_replies[75], need_new_cid[76], zero[79:77]
    output logic [2:0]  m_tuser,    // action
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import hmr_pkg::*;

    hmr_cfg_t    cfg;
    hmr_item_t   item_reg;
    logic        in_valid_reg;
    logic        out_valid_reg;
    hmr_result_t result;
    hmr_result_t result_reg;
    logic        advance;

    hmr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_idx_t'(cfg_index)),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // item moves from the input register into the result register
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // payload capture, no reset needed
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.req_type   <= s_tuser;
            item_reg.frame_cid  <= s_tdata[31:0];
            item_reg.frame_kind <= s_tdata[39:32];
            item_reg.frame_len  <= s_tdata[55:40];
        end
    end

    // channel state and decision logic; state commits when the item advances
    hmr_core #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .item    (item_reg),
        .step    (advance),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = result_reg.action;
    assign m_tdata  = {3'b000,
                       result_reg.need_new_cid,
                       result_reg.flush_replies,
                       result_reg.msg_length,
                       result_reg.msg_cmd,
                       result_reg.chunk_bytes,
                       result_reg.write_offset,
                       result_reg.error_kind,
                       result_reg.reply_cid};

    // every error result names its error
    `HMR_ASSERT_IMPLIES(a_err_named, aclk, aresetn, out_valid_reg && result_reg.action == ACT_ERR, result_reg.error_kind != ERR_NONE)
    // a fresh channel is only requested by a channel-init reply
    `HMR_ASSERT_IMPLIES(a_new_cid_init, aclk, aresetn, out_valid_reg && result_reg.need_new_cid, result_reg.action == ACT_INIT)
    // an advancing item always lands in the result register
    `HMR_ASSERT_NEXT(a_advance_lands, aclk, aresetn, advance, out_valid_reg)

endmodule
